// File: rtl/adcsm_pkg.sv
// shared constants and types of the multichannel converter smoother
`timescale 1ns / 1ps
package adcsm_pkg;

	localparam int SCALE_BITS = 10;
	localparam int CHANNELS   = 5;
	localparam int NUM_REGS   = 5;
	localparam int CHAN_W     = 3;
	localparam int REG_IDX_W  = 3;
	localparam int SAMPLE_W   = 10;
	localparam int DATA_W     = 16;
	localparam int ALPHA_W    = 11;
	localparam int RAW_SHIFT  = 6;
	localparam int ADDR_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int COEF_W     = SCALE_BITS + 1;
	localparam int ACC_W      = DATA_W + SCALE_BITS + 1;
	localparam int CMP_W      = (COEF_W > ALPHA_W) ? COEF_W : ALPHA_W;

	localparam logic [COEF_W-1:0]  SCALE_ONE = COEF_W'(1) << SCALE_BITS;
	localparam logic [ACC_W-1:0]   ROUND_HALF = ACC_W'(1) << (SCALE_BITS - 1);
	localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'((98 * (1 << SCALE_BITS)) / 100);

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
	} store_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} store_rd_t;

endpackage

// File: rtl/adcsm_store.sv
// per-channel filter state memory with registered read
`timescale 1ns / 1ps
module adcsm_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  adcsm_pkg::store_rd_t      rd,
	input  adcsm_pkg::store_wr_t      wr,
	output logic [adcsm_pkg::DATA_W-1:0] rd_data
);
	import adcsm_pkg::*;

	logic [DATA_W-1:0]   mem [CHANNELS];
	logic [CHANNELS-1:0] vld_q;
	logic [DATA_W-1:0]   rd_q;
	logic                rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_q <= mem[rd.addr];
		end
	end

	// entries never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_vld_q <= vld_q[rd.addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

// File: rtl/adcsm_alpha_regs.sv
// per-channel smoothing weight registers with saturation to full scale
`timescale 1ns / 1ps
module adcsm_alpha_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [adcsm_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [adcsm_pkg::ALPHA_W-1:0]   cfg_wdata,
	input  logic [adcsm_pkg::CHAN_W-1:0]    sel_chan,
	output logic [adcsm_pkg::COEF_W-1:0]    coef
);
	import adcsm_pkg::*;

	logic [ALPHA_W-1:0] alpha_q [NUM_REGS];
	logic [ALPHA_W-1:0] alpha_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				alpha_q[i] <= ALPHA_RST;
			end
		end else if (cfg_we && (cfg_addr < REG_IDX_W'(NUM_REGS))) begin
			alpha_q[cfg_addr] <= cfg_wdata;
		end
	end

	always_comb begin
		alpha_sel = '0;
		if (sel_chan < CHAN_W'(NUM_REGS)) begin
			alpha_sel = alpha_q[sel_chan];
		end
	end

	// weight above full scale holds the old value
	assign coef = (CMP_W'(alpha_sel) > CMP_W'(SCALE_ONE)) ? SCALE_ONE : COEF_W'(alpha_sel);

endmodule

// File: rtl/multichannel_adc_iir_smoother_core.sv
// top level: converter sample smoother with per-channel read-modify-write filter state
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, chan, sample          | request in
//  out     | out_valid, out_ready, chan_out,           | request out
//          | raw_scaled, smoothed                      |
//  cfg     | cfg_we, cfg_addr, cfg_wdata               | write only
//
// one request per cycle sustained unless the output stalls; accept reads the
// state memory and forms the new-sample product, the update stage multiplies
// the old value and writes it back, then the output register takes the result;
// same-channel back-to-back requests take the written value through a bypass
// reset clears all state to zero and weights to 0.98 of full scale, no init pass
// out_ready low stalls the update stage and then in_ready
`timescale 1ns / 1ps
module multichannel_adc_iir_smoother_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [adcsm_pkg::CHAN_W-1:0]    chan,
	input  logic [adcsm_pkg::SAMPLE_W-1:0]  sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [adcsm_pkg::CHAN_W-1:0]    chan_out,
	output logic [adcsm_pkg::DATA_W-1:0]    raw_scaled,
	output logic [adcsm_pkg::DATA_W-1:0]    smoothed,
	input  logic                            cfg_we,
	input  logic [adcsm_pkg::REG_IDX_W-1:0] cfg_addr,
	input  logic [adcsm_pkg::ALPHA_W-1:0]   cfg_wdata
);
	import adcsm_pkg::*;

	logic              accept;
	logic              adv_s1;
	logic              in_range;
	logic [DATA_W-1:0] raw;
	logic [COEF_W-1:0] coef;
	logic [ACC_W-1:0]  part;
	store_rd_t         store_rd;
	store_wr_t         store_wr;
	logic [DATA_W-1:0] rd_data;

	logic              valid_s1;
	logic [CHAN_W-1:0] chan_s1;
	logic [DATA_W-1:0] raw_s1;
	logic              in_range_s1;
	logic [COEF_W-1:0] coef_s1;
	logic [ACC_W-1:0]  part_s1;
	logic              fwd_s1;
	logic [DATA_W-1:0] fwd_data_s1;

	logic [DATA_W-1:0] old_val;
	logic [ACC_W-1:0]  acc;
	logic [DATA_W-1:0] new_val;

	logic              out_valid_q;
	logic [CHAN_W-1:0] chan_out_q;
	logic [DATA_W-1:0] raw_scaled_q;
	logic [DATA_W-1:0] smoothed_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;
	assign in_range = chan < CHAN_W'(CHANNELS);
	assign raw      = DATA_W'(sample) << RAW_SHIFT;

	adcsm_alpha_regs u_alpha (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.sel_chan  (chan),
		.coef      (coef)
	);

	// new-sample term with rounding, independent of the stored value
	assign part = ACC_W'(raw) * ACC_W'(SCALE_ONE - coef) + ROUND_HALF;

	assign store_rd.en   = accept && in_range;
	assign store_rd.addr = ADDR_W'(chan);

	adcsm_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (store_rd),
		.wr      (store_wr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chan_s1     <= chan;
			raw_s1      <= raw;
			in_range_s1 <= in_range;
			coef_s1     <= coef;
			part_s1     <= part;
			// same channel written back at this edge: memory read is stale
			fwd_s1      <= store_wr.en && (chan_s1 == chan);
			fwd_data_s1 <= new_val;
		end
	end

	assign old_val = fwd_s1 ? fwd_data_s1 : rd_data;
	assign acc     = ACC_W'(old_val) * ACC_W'(coef_s1) + part_s1;
	assign new_val = acc[SCALE_BITS +: DATA_W];

	assign store_wr.en   = adv_s1 && in_range_s1;
	assign store_wr.addr = ADDR_W'(chan_s1);
	assign store_wr.data = new_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			chan_out_q   <= chan_s1;
			raw_scaled_q <= raw_s1;
			smoothed_q   <= in_range_s1 ? new_val : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign chan_out   = chan_out_q;
	assign raw_scaled = raw_scaled_q;
	assign smoothed   = smoothed_q;

`ifndef ASSERT_OFF
	a_wr_lands_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		store_wr.en |=> out_valid_q)
		else $error("state write without a result");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (chan_out_q >= CHAN_W'(CHANNELS))) |-> (smoothed_q == '0))
		else $error("out-of-range channel gave nonzero result");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled without a full pipeline");

	a_fwd_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !(store_wr.en && (chan_s1 == chan))) |=> !fwd_s1)
		else $error("bypass taken without a write-back");
`endif

endmodule

// File: tb/multichannel_adc_iir_smoother_core_tb.sv
// self-checking testbench of the multichannel converter smoother core
`timescale 1ns / 1ps
module multichannel_adc_iir_smoother_core_tb;
	import adcsm_pkg::*;

	localparam int REG_ALPHA_CH0 = 0;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int ALPHA_MAX     = (1 << ALPHA_W) - 1;
	localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;

	typedef struct {
		logic [CHAN_W-1:0] chan;
		logic [DATA_W-1:0] raw;
		logic [DATA_W-1:0] smoothed;
	} smooth_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [CHAN_W-1:0]    chan = '0;
	logic [SAMPLE_W-1:0]  sample = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CHAN_W-1:0]    chan_out;
	logic [DATA_W-1:0]    raw_scaled;
	logic [DATA_W-1:0]    smoothed;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_addr = '0;
	logic [ALPHA_W-1:0]   cfg_wdata = '0;

	// shadow copy of the block state
	logic [ALPHA_W-1:0] weight_shadow [CHANNELS];
	logic [DATA_W-1:0]  filter_shadow [CHANNELS];
	smooth_result_t     expected_results [$];

	int fail_count = 0;
	int cycle_count = 0;
	int rx_hold_left = 0;
	int rx_pause_left = 0;
	int rx_run_left = 0;
	bit rx_always_ready = 1'b0;
	int tx_burst_left = 0;

	multichannel_adc_iir_smoother_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.chan(chan),
		.sample(sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chan_out(chan_out),
		.raw_scaled(raw_scaled),
		.smoothed(smoothed),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int next_tx_gap();
		if (tx_burst_left > 0) begin
			tx_burst_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			tx_burst_left = $urandom_range(10, 40);
		return rand_gap();
	endfunction

	function automatic logic [CHAN_W-1:0] pick_chan();
		if ($urandom_range(0, 9) == 0)
			return CHAN_W'($urandom_range(CHANNELS, (1 << CHAN_W) - 1));
		return CHAN_W'($urandom_range(0, CHANNELS - 1));
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return SAMPLE_W'(SAMPLE_MAX);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [ALPHA_W-1:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return SCALE_ONE;
			2: return ALPHA_W'($urandom_range(SCALE_ONE + 1, ALPHA_MAX));
			3: return ALPHA_W'(1);
			4, 5: return ALPHA_W'($urandom_range(SCALE_ONE - 64, SCALE_ONE - 1));
			default: return ALPHA_W'($urandom_range(0, ALPHA_MAX));
		endcase
	endfunction

	task automatic predict_smooth(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
		smooth_result_t     res;
		logic [ALPHA_W-1:0] w;
		logic [63:0]        acc;
		int                 idx;
		idx = int'(ch);
		res.chan = ch;
		res.raw = DATA_W'({s, {RAW_SHIFT{1'b0}}});
		res.smoothed = '0;
		// out-of-range channel leaves the store alone and reports zero
		if (idx < CHANNELS) begin
			w = (weight_shadow[idx] > SCALE_ONE) ? ALPHA_W'(SCALE_ONE) : weight_shadow[idx];
			acc = 64'(filter_shadow[idx]) * 64'(w) + 64'(res.raw) * 64'(SCALE_ONE - w)
				+ 64'(SCALE_ONE >> 1);
			res.smoothed = acc[SCALE_BITS +: DATA_W];
			filter_shadow[idx] = res.smoothed;
		end
		expected_results.push_back(res);
	endtask

	task automatic check_result();
		smooth_result_t want;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result chan %0d raw %0d smoothed %0d", $time, chan_out,
				raw_scaled, smoothed);
			fail_count++;
		end else begin
			want = expected_results.pop_front();
			if (chan_out !== want.chan) begin
				$display("%0t: chan_out expected %0d actual %0d", $time, want.chan, chan_out);
				fail_count++;
			end
			if (raw_scaled !== want.raw) begin
				$display("%0t: raw_scaled expected %0d actual %0d", $time, want.raw, raw_scaled);
				fail_count++;
			end
			if (smoothed !== want.smoothed) begin
				$display("%0t: smoothed expected %0d actual %0d (chan %0d)", $time,
					want.smoothed, smoothed, want.chan);
				fail_count++;
			end
		end
	endtask

	// receiver: checks each result and paces out_ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			check_result();
		if (rx_hold_left > 0) begin
			out_ready <= 1'b0;
			rx_hold_left--;
		end else if (rx_always_ready || rx_run_left > 0) begin
			out_ready <= 1'b1;
			if (rx_run_left > 0)
				rx_run_left--;
		end else if (rx_pause_left > 0) begin
			out_ready <= 1'b0;
			rx_pause_left--;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 11) == 0)
				rx_run_left = $urandom_range(20, 80);
			else
				rx_pause_left = rand_gap();
		end
	end

	// valid stays high after accept; the next call either reloads or drops it
	task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] s,
		input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		chan <= ch;
		sample <= s;
		do @(posedge clk); while (!in_ready);
		predict_smooth(ch, s);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// block must be idle; also pokes the unused indexes, which must be ignored
	task automatic program_weights(input logic [ALPHA_W-1:0] w [CHANNELS]);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= REG_IDX_W'(REG_ALPHA_CH0 + i);
			cfg_wdata <= w[i];
			@(posedge clk);
			weight_shadow[i] = w[i];
		end
		for (int i = NUM_REGS; i < (1 << REG_IDX_W); i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= REG_IDX_W'(i);
			cfg_wdata <= ALPHA_W'($urandom_range(0, ALPHA_MAX));
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic test_default_weights();
		send_sample(CHAN_W'(0), SAMPLE_W'(SAMPLE_MAX), 0);
		send_sample(CHAN_W'(1), '0, 0);
		send_sample(CHAN_W'(2), SAMPLE_W'(SAMPLE_MAX), 1);
		send_sample(CHAN_W'(3), SAMPLE_W'(512), 0);
		send_sample(CHAN_W'(4), SAMPLE_W'(SAMPLE_MAX), 0);
		send_sample(CHAN_W'(0), SAMPLE_W'(SAMPLE_MAX), 0);
		send_sample(CHAN_W'(0), SAMPLE_W'(SAMPLE_MAX), 2);
		send_sample(CHAN_W'(5), SAMPLE_W'(SAMPLE_MAX), 0);
		send_sample(CHAN_W'(6), '0, 0);
		send_sample(CHAN_W'(7), SAMPLE_W'(SAMPLE_MAX), 1);
		wait_drained();
	endtask

	task automatic test_weight_extremes();
		logic [ALPHA_W-1:0] w [CHANNELS];
		// zero passes the sample through, full scale and above hold the old value
		w[0] = '0;
		w[1] = SCALE_ONE;
		w[2] = ALPHA_W'(ALPHA_MAX);
		w[3] = ALPHA_W'(1);
		w[4] = ALPHA_W'(SCALE_ONE + 1);
		program_weights(w);
		for (int c = 0; c < CHANNELS; c++) begin
			send_sample(CHAN_W'(c), SAMPLE_W'(SAMPLE_MAX), 0);
			send_sample(CHAN_W'(c), '0, c % 2);
		end
		send_sample(CHAN_W'(7), SAMPLE_W'(SAMPLE_MAX), 0);
		wait_drained();
	endtask

	task automatic test_random_weights();
		logic [ALPHA_W-1:0] w [CHANNELS];
		for (int phase = 0; phase < 7; phase++) begin
			for (int c = 0; c < CHANNELS; c++)
				w[c] = pick_weight();
			program_weights(w);
			repeat (175) send_sample(pick_chan(), pick_sample(), next_tx_gap());
			wait_drained();
		end
	endtask

	task automatic test_output_stall();
		// long receiver hold while the sender keeps offering, so in_ready drops
		rx_hold_left = 300;
		repeat (40) send_sample(pick_chan(), pick_sample(), 0);
		wait_drained();
		repeat (40) send_sample(pick_chan(), pick_sample(), rand_gap());
		wait_drained();
	endtask

	task automatic test_same_channel_bursts();
		logic [CHAN_W-1:0] ch;
		// back-to-back requests on one channel exercise the write-back bypass
		rx_always_ready = 1'b1;
		ch = pick_chan();
		repeat (150) begin
			if ($urandom_range(0, 3) == 0)
				ch = pick_chan();
			send_sample(ch, pick_sample(), 0);
		end
		wait_drained();
		rx_always_ready = 1'b0;
	endtask

	initial begin
		for (int c = 0; c < CHANNELS; c++) begin
			weight_shadow[c] = ALPHA_RST;
			filter_shadow[c] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_weights();
		test_weight_extremes();
		test_random_weights();
		test_output_stall();
		test_same_channel_bursts();
		wait_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: multichannel_adc_iir_smoother_core.f
rtl/adcsm_pkg.sv
rtl/adcsm_store.sv
rtl/adcsm_alpha_regs.sv
rtl/multichannel_adc_iir_smoother_core.sv
tb/multichannel_adc_iir_smoother_core_tb.sv
